/* src/dual_stack_shared_memory_macros.svh */
// Assertion macros for the dual stack shared memory block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef DUAL_STACK_SHARED_MEMORY_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dssm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dssm assertion failed");

`endif

/* src/dssm_pkg.sv */
// Package for the dual stack shared memory block: item types and codes.
// No dependencies; used by dssm_ctrl and dual_stack_shared_memory.
`timescale 1ns / 1ps

package dssm_pkg;

    // Operation codes.
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Data returned for an empty stack, and for pushes and unused modes.
    localparam logic signed [31:0] EMPTY_DATA = -32'sd1;
    localparam logic signed [31:0] ZERO_DATA  = 32'sd0;

    // Request item.
    typedef struct packed {
        logic [1:0]         mode;
        logic               which_stack;
        logic signed [31:0] push_value;
    } t_req;

    // Result item.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [7:0]         size_a;
        logic [7:0]         size_b;
    } t_rsp;

endpackage

/* src/dssm_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies; instantiated by dual_stack_shared_memory.
`timescale 1ns / 1ps

module dssm_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dssm_ctrl.sv */
// Stack controller: both stack counters, memory addressing and the result register.
// Depends on dssm_pkg and dual_stack_shared_memory_macros.svh.
`timescale 1ns / 1ps
`include "dual_stack_shared_memory_macros.svh"

module dssm_ctrl #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  dssm_pkg::t_req i_req,
    output logic           o_valid,
    output dssm_pkg::t_rsp o_rsp,
    output logic           o_we,
    output logic [AW-1:0]  o_waddr,
    output logic [31:0]    o_wdata,
    output logic           o_re,
    output logic [AW-1:0]  o_raddr,
    input  logic [31:0]    i_rdata
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt_a;
    logic [CW-1:0]   r_cnt_b;
    logic [1:0]      r_status;
    logic            r_use_mem;
    logic            r_valid;
    dssm_pkg::t_rsp  r_rsp;

    logic            accept;
    logic            is_b;
    logic [CW-1:0]   cnt_sel;
    logic [CW:0]     total;
    logic            full;
    logic            empty;
    logic            is_push;
    logic            is_read;
    logic            push_ok;
    logic            rd_ok;
    logic            pop_ok;
    logic [1:0]      n_status;
    logic [CW-1:0]   wslot;
    logic [CW-1:0]   rslot;
    logic [31:0]     wide_a;
    logic [31:0]     wide_b;
    logic signed [31:0] resp_data;

    // Request decode against the current counters.
    assign accept  = i_start && (r_state == S_IDLE);
    assign is_b    = i_req.which_stack;
    assign cnt_sel = is_b ? r_cnt_b : r_cnt_a;
    assign total   = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign full    = (total >= DEPTH_S);
    assign empty   = (cnt_sel == '0);
    assign is_push = (i_req.mode == dssm_pkg::MODE_PUSH);
    assign is_read = (i_req.mode == dssm_pkg::MODE_POP) || (i_req.mode == dssm_pkg::MODE_PEEK);
    assign push_ok = is_push && !full;
    assign rd_ok   = is_read && !empty;
    assign pop_ok  = (i_req.mode == dssm_pkg::MODE_POP) && !empty;

    // Status of the item, known at acceptance.
    always_comb begin
        case (i_req.mode)
            dssm_pkg::MODE_PUSH: n_status = full ? dssm_pkg::ST_FULL : dssm_pkg::ST_OK;
            dssm_pkg::MODE_POP,
            dssm_pkg::MODE_PEEK: n_status = empty ? dssm_pkg::ST_EMPTY : dssm_pkg::ST_OK;
            default:             n_status = dssm_pkg::ST_OK;
        endcase
    end

    // Stack A grows up from entry 0, stack B down from the last entry.
    assign wslot = is_b ? (DEPTH_C - CW'(1) - r_cnt_b) : r_cnt_a;
    assign rslot = is_b ? (DEPTH_C - r_cnt_b) : (r_cnt_a - CW'(1));

    assign o_we    = accept && push_ok;
    assign o_waddr = wslot[AW-1:0];
    assign o_wdata = i_req.push_value;
    assign o_re    = accept && rd_ok;
    assign o_raddr = rslot[AW-1:0];

    // Result data once the memory read has landed.
    always_comb begin
        if (r_use_mem) begin
            resp_data = i_rdata;
        end else if (r_status == dssm_pkg::ST_EMPTY) begin
            resp_data = dssm_pkg::EMPTY_DATA;
        end else begin
            resp_data = dssm_pkg::ZERO_DATA;
        end
    end

    // Sizes are reported modulo 256.
    assign wide_a = 32'(r_cnt_a);
    assign wide_b = 32'(r_cnt_b);

    // Sequencer, counters and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_valid   <= 1'b0;
            r_status  <= dssm_pkg::ST_OK;
            r_use_mem <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status  <= n_status;
                        r_use_mem <= rd_ok;
                        if (push_ok && !is_b) begin
                            r_cnt_a <= r_cnt_a + CW'(1);
                        end
                        if (push_ok && is_b) begin
                            r_cnt_b <= r_cnt_b + CW'(1);
                        end
                        if (pop_ok && !is_b) begin
                            r_cnt_a <= r_cnt_a - CW'(1);
                        end
                        if (pop_ok && is_b) begin
                            r_cnt_b <= r_cnt_b - CW'(1);
                        end
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_rsp.read_value <= resp_data;
                    r_rsp.status     <= r_status;
                    r_rsp.size_a     <= wide_a[7:0];
                    r_rsp.size_b     <= wide_b[7:0];
                    r_valid          <= 1'b1;
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state == S_RESP);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // The two stacks never claim more entries than the memory holds.
    `DSSM_ASSERT_IMP(a_cap, i_clk, i_rst_n, 1'b1, total <= DEPTH_S)
    // An accepted item always moves the sequencer to S_RESP, which then registers the result and raises o_valid.
    `DSSM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, o_busy)
    `DSSM_ASSERT_NXT(a_busy_valid, i_clk, i_rst_n, o_busy, o_valid)
    // A refused push only happens with the memory completely used.
    `DSSM_ASSERT_IMP(a_full_sum, i_clk, i_rst_n, o_valid && (o_rsp.status == dssm_pkg::ST_FULL), total == DEPTH_S)
    // An empty stack reports all ones.
    `DSSM_ASSERT_IMP(a_empty_data, i_clk, i_rst_n, o_valid && (o_rsp.status == dssm_pkg::ST_EMPTY), o_rsp.read_value == dssm_pkg::EMPTY_DATA)

endmodule

/* src/dual_stack_shared_memory.sv */
// Channel    | Handshake              | Payload
// request    | start && !busy         | i_req  (dssm_pkg::t_req)
// result     | o_valid, one cycle     | o_rsp  (dssm_pkg::t_rsp)
//
// An item is accepted in S_IDLE: the acceptance edge issues the memory read or write
// and updates the counters; in S_RESP the result is registered off the RAM read
// port, and o_valid is high in the cycle after that. busy is high for one cycle
// per item, so a new item can be accepted in the cycle that shows the result.
// Reset is synchronous and active low; it empties both stacks, memory contents
// are left as they are. The receiver cannot stall the result.
//
// Top level of the dual stack shared memory; depends on dssm_pkg, dssm_ram, dssm_ctrl.
`timescale 1ns / 1ps

module dual_stack_shared_memory #(
    parameter int DEPTH = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dssm_pkg::t_req i_req,
    output logic           o_valid,
    output dssm_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    // Counters, addressing and result register.
    dssm_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .o_we    (mem_we),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_re    (mem_re),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    // Shared storage for both stacks.
    dssm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
